// ----- hdl/csw_pkg.sv -----
// ----------------------------------------------------------------------------
// Circular sway trajectory generator - shared definitions
// Widths, register indexes, reset values, the CORDIC angle table and the
// position saturation used by the generator and its datapath units.
// ----------------------------------------------------------------------------
package csw_pkg;

  // Field widths. The phase is a full 32-bit fraction of a turn.
  localparam int POS_BITS      = 24;
  localparam int RADIUS_BITS   = POS_BITS - 1;
  localparam int PHASE_BITS    = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // CORDIC datapath: Q30 vector, angle in units of 2^-32 turn.
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_BITS    = 4;
  localparam int VEC_BITS     = 33;
  localparam int ANG_BITS     = 32;
  localparam logic signed [VEC_BITS-1:0] CORDIC_GAIN = 33'sd652032874;

  // Serial multiplier: signed multiplier operand, high half of the product.
  localparam int MUL_BITS  = POS_BITS;
  localparam int CNT_BITS  = 5;
  localparam int HI_BITS   = VEC_BITS + 1;
  localparam int PROD_BITS = 28;
  localparam int SUM_BITS  = PROD_BITS + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Z     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SWAY_AMP     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS       = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_REACH        = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_SWAY_STEP    = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_CIRCLE_STEP  = 3'd7;

  // Register reset values.
  localparam logic [POS_BITS-1:0]    RST_SWAY_AMP    = 24'd104858;
  localparam logic [RADIUS_BITS-1:0] RST_RADIUS      = 23'd52429;
  localparam logic [RADIUS_BITS-1:0] RST_REACH       = 23'd471859;
  localparam logic [PHASE_BITS-1:0]  RST_PHASE_STEP  = 32'd21474836;

  // Saturation bounds of a position.
  localparam logic signed [SUM_BITS-1:0] POS_MAX = 29'sd8388607;
  localparam logic signed [SUM_BITS-1:0] POS_MIN = -29'sd8388608;

  // atan(2^-i) in units of 2^-32 turn, truncated.
  function automatic logic signed [ANG_BITS-1:0] atan_turn(input logic [STEP_BITS-1:0] idx);
    logic signed [ANG_BITS-1:0] a;
    case (idx)
      4'd0:    a = 32'sd536870912;
      4'd1:    a = 32'sd316933406;
      4'd2:    a = 32'sd167458907;
      4'd3:    a = 32'sd85004756;
      4'd4:    a = 32'sd42667330;
      4'd5:    a = 32'sd21354465;
      4'd6:    a = 32'sd10679838;
      4'd7:    a = 32'sd5340245;
      4'd8:    a = 32'sd2670163;
      4'd9:    a = 32'sd1335086;
      4'd10:   a = 32'sd667544;
      4'd11:   a = 32'sd333772;
      4'd12:   a = 32'sd166886;
      4'd13:   a = 32'sd83443;
      4'd14:   a = 32'sd41721;
      default: a = 32'sd20860;
    endcase
    return a;
  endfunction

  // Clamp a widened position to the signed position range.
  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [SUM_BITS-1:0] v);
    logic signed [SUM_BITS-1:0] c;
    if (v > POS_MAX) begin
      c = POS_MAX;
    end else if (v < POS_MIN) begin
      c = POS_MIN;
    end else begin
      c = v;
    end
    return c[POS_BITS-1:0];
  endfunction

endpackage

// ----- hdl/csw_if.sv -----
// ----------------------------------------------------------------------------
// Circular sway trajectory generator - channel interfaces
// Valid/ready channels for the tick beats and for the target point beats.
// ----------------------------------------------------------------------------
interface csw_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface csw_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [csw_pkg::POS_BITS-1:0] target_x;
  logic signed [csw_pkg::POS_BITS-1:0] target_y;
  logic signed [csw_pkg::POS_BITS-1:0] target_z;

  modport source (output valid, output target_x, output target_y, output target_z,
                  input ready);
  modport sink   (input valid, input target_x, input target_y, input target_z,
                  output ready);
endinterface

// ----- hdl/csw_cordic.sv -----
// ----------------------------------------------------------------------------
// Circular sway trajectory generator - iterative CORDIC
// Rotation-mode CORDIC, one micro-rotation per cycle, giving cosine and sine
// of a 32-bit turn fraction in Q30 after quadrant folding.
// ----------------------------------------------------------------------------
module csw_cordic (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [csw_pkg::PHASE_BITS-1:0]        turn_i,
  output logic                                  busy_o,
  output logic signed [csw_pkg::VEC_BITS-1:0]   cos_o,
  output logic signed [csw_pkg::VEC_BITS-1:0]   sin_o
);

  logic                                busy_q, busy_d;
  logic [csw_pkg::STEP_BITS-1:0]       step_q, step_d;
  logic [1:0]                          quad_q, quad_d;
  logic signed [csw_pkg::VEC_BITS-1:0] x_q, x_d, y_q, y_d;
  logic signed [csw_pkg::ANG_BITS-1:0] z_q, z_d;
  logic signed [csw_pkg::VEC_BITS-1:0] x_sh, y_sh;

  // Arithmetic shifts round toward minus infinity.
  assign x_sh = x_q >>> step_q;
  assign y_sh = y_q >>> step_q;

  // One micro-rotation per cycle, direction from the sign of the residual angle.
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    quad_d = quad_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quad_d = turn_i[csw_pkg::PHASE_BITS-1 -: 2];
      x_d    = csw_pkg::CORDIC_GAIN;
      y_d    = '0;
      z_d    = {2'b00, turn_i[csw_pkg::PHASE_BITS-3:0]};
    end else if (busy_q) begin
      if (!z_q[csw_pkg::ANG_BITS-1]) begin
        x_d = x_q - y_sh;
        y_d = y_q + x_sh;
        z_d = z_q - csw_pkg::atan_turn(step_q);
      end else begin
        x_d = x_q + y_sh;
        y_d = y_q - x_sh;
        z_d = z_q + csw_pkg::atan_turn(step_q);
      end
      step_d = step_q + 1'b1;
      if (step_q == csw_pkg::STEP_BITS'(csw_pkg::CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    quad_q <= quad_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  // Fold the first-quadrant result back into the full circle.
  always_comb begin
    case (quad_q)
      2'd0: begin
        cos_o = x_q;
        sin_o = y_q;
      end
      2'd1: begin
        cos_o = -y_q;
        sin_o = x_q;
      end
      2'd2: begin
        cos_o = -x_q;
        sin_o = -y_q;
      end
      default: begin
        cos_o = y_q;
        sin_o = -x_q;
      end
    endcase
  end

  assign busy_o = busy_q;

endmodule

// ----- hdl/csw_sermul.sv -----
// ----------------------------------------------------------------------------
// Circular sway trajectory generator - bit-serial Q30 multiplier
// Multiplies a signed Q30 value by a signed position one multiplier bit per
// cycle, keeping only the high half, and rounds the product out of Q30.
// ----------------------------------------------------------------------------
module csw_sermul (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [csw_pkg::VEC_BITS-1:0]   frac_i,
  input  logic signed [csw_pkg::MUL_BITS-1:0]   scale_i,
  output logic                                  busy_o,
  output logic signed [csw_pkg::PROD_BITS-1:0]  prod_o
);

  logic                                busy_q, busy_d;
  logic [csw_pkg::CNT_BITS-1:0]        cnt_q, cnt_d;
  logic signed [csw_pkg::VEC_BITS-1:0] frac_q, frac_d;
  logic [csw_pkg::MUL_BITS-1:0]        bits_q, bits_d;
  logic signed [csw_pkg::HI_BITS-1:0]  hi_q, hi_d;
  logic signed [csw_pkg::HI_BITS-1:0]  addend, sum;
  logic signed [csw_pkg::HI_BITS-1:0]  rounded;
  logic                                last;

  assign last   = (cnt_q == csw_pkg::CNT_BITS'(csw_pkg::MUL_BITS - 1));
  assign addend = bits_q[0] ? csw_pkg::HI_BITS'(frac_q) : '0;
  // The top multiplier bit carries negative weight.
  assign sum    = last ? (hi_q - addend) : (hi_q + addend);

  // Multiplier bits leave a shift register LSB first; the partial product
  // moves right so only its high half is kept.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    frac_d = frac_q;
    bits_d = bits_q;
    hi_d   = hi_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      frac_d = frac_i;
      bits_d = scale_i;
      hi_d   = '0;
    end else if (busy_q) begin
      hi_d   = sum >>> 1;
      bits_d = bits_q >> 1;
      cnt_d  = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    frac_q <= frac_d;
    bits_q <= bits_d;
    hi_q   <= hi_d;
  end

  // The kept half is the product over 2^24; add half an LSB of Q30 and drop 6 more bits.
  assign rounded = (hi_q + csw_pkg::HI_BITS'(32)) >>> 6;
  assign prod_o  = rounded[csw_pkg::PROD_BITS-1:0];
  assign busy_o  = busy_q;

endmodule

// ----- hdl/circular_sway_trajectory_generator.sv -----
// ----------------------------------------------------------------------------
// Circular sway trajectory generator
// Two phase accumulators drive a circle in x/z and a sinusoidal sway in y.
// ----------------------------------------------------------------------------
// Usage:
//   Each beat on in_ch is one control tick. restart = 1 clears both phases,
//   otherwise each phase advances by its step register. One beat on out_ch
//   follows every tick and carries target_x, target_y and target_z.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//   no tick is in flight; writes take effect on the next tick.
// Sequence:
//   A tick runs from acceptance to a valid point through the two CORDIC units
//   (one micro-rotation per cycle, running side by side), then through the
//   three bit-serial multipliers (one multiplier bit per cycle), plus sequencing.
//   One tick is in work at a time, so a new tick is accepted only once the
//   previous point has been handed to the output register.
// Reset and stalls:
//   Reset clears both phases and loads the register defaults. A finished point
//   waits in the output register; the next tick is still accepted and worked
//   on, and it holds its result until the output register is free.
// ----------------------------------------------------------------------------
module circular_sway_trajectory_generator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [csw_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [csw_pkg::CFG_DATA_BITS-1:0]    cfg_wdata_i,
  csw_in_if.sink                               in_ch,
  csw_out_if.source                            out_ch
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CSTART = 3'd1;
  localparam logic [2:0] ST_CRUN   = 3'd2;
  localparam logic [2:0] ST_MSTART = 3'd3;
  localparam logic [2:0] ST_MRUN   = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  // Configuration registers.
  logic signed [csw_pkg::POS_BITS-1:0]    center_x_q, center_y_q, center_z_q, sway_amp_q;
  logic [csw_pkg::RADIUS_BITS-1:0]        radius_q, reach_q;
  logic [csw_pkg::PHASE_BITS-1:0]         sway_step_q, circle_step_q;

  // Phase accumulators and sequencer.
  logic [csw_pkg::PHASE_BITS-1:0]         sway_phase_q, circle_phase_q;
  logic [2:0]                             state_q, state_d;
  logic                                   in_accept, out_free;

  // Output register.
  logic                                   out_valid_q, out_valid_d;
  logic signed [csw_pkg::POS_BITS-1:0]    tx_q, ty_q, tz_q;

  // Datapath wiring.
  logic                                   cordic_start, mul_start;
  logic                                   circ_busy, sway_busy;
  logic                                   mx_busy, my_busy, mz_busy;
  logic signed [csw_pkg::VEC_BITS-1:0]    circ_cos, circ_sin, sway_cos, sway_sin;
  logic [csw_pkg::RADIUS_BITS-1:0]        radius_eff;
  logic signed [csw_pkg::MUL_BITS-1:0]    radius_op;
  logic signed [csw_pkg::PROD_BITS-1:0]   prod_x, prod_y, prod_z;
  logic signed [csw_pkg::SUM_BITS-1:0]    sum_x, sum_y, sum_z;

  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_q || out_ch.ready;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q    <= '0;
      center_y_q    <= '0;
      center_z_q    <= '0;
      sway_amp_q    <= csw_pkg::RST_SWAY_AMP;
      radius_q      <= csw_pkg::RST_RADIUS;
      reach_q       <= csw_pkg::RST_REACH;
      sway_step_q   <= csw_pkg::RST_PHASE_STEP;
      circle_step_q <= csw_pkg::RST_PHASE_STEP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        csw_pkg::REG_CENTER_X:    center_x_q    <= cfg_wdata_i[csw_pkg::POS_BITS-1:0];
        csw_pkg::REG_CENTER_Y:    center_y_q    <= cfg_wdata_i[csw_pkg::POS_BITS-1:0];
        csw_pkg::REG_CENTER_Z:    center_z_q    <= cfg_wdata_i[csw_pkg::POS_BITS-1:0];
        csw_pkg::REG_SWAY_AMP:    sway_amp_q    <= cfg_wdata_i[csw_pkg::POS_BITS-1:0];
        csw_pkg::REG_RADIUS:      radius_q      <= cfg_wdata_i[csw_pkg::RADIUS_BITS-1:0];
        csw_pkg::REG_REACH:       reach_q       <= cfg_wdata_i[csw_pkg::RADIUS_BITS-1:0];
        csw_pkg::REG_SWAY_STEP:   sway_step_q   <= cfg_wdata_i[csw_pkg::PHASE_BITS-1:0];
        csw_pkg::REG_CIRCLE_STEP: circle_step_q <= cfg_wdata_i[csw_pkg::PHASE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Phase accumulators: cleared on restart, otherwise advanced with wraparound.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sway_phase_q   <= '0;
      circle_phase_q <= '0;
    end else if (in_accept) begin
      if (in_ch.restart) begin
        sway_phase_q   <= '0;
        circle_phase_q <= '0;
      end else begin
        sway_phase_q   <= sway_phase_q + sway_step_q;
        circle_phase_q <= circle_phase_q + circle_step_q;
      end
    end
  end

  // Sequencer: phases, CORDIC, multiply, then hand the point to the output.
  always_comb begin
    state_d      = state_q;
    cordic_start = 1'b0;
    mul_start    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_CSTART;
        end
      end
      ST_CSTART: begin
        cordic_start = 1'b1;
        state_d      = ST_CRUN;
      end
      ST_CRUN: begin
        if (!circ_busy && !sway_busy) begin
          state_d = ST_MSTART;
        end
      end
      ST_MSTART: begin
        mul_start = 1'b1;
        state_d   = ST_MRUN;
      end
      ST_MRUN: begin
        if (!mx_busy && !my_busy && !mz_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ch.ready = (state_q == ST_IDLE);

  // Two CORDIC units work on the circle and sway phases side by side.
  csw_cordic u_cordic_circle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .turn_i  (circle_phase_q),
    .busy_o  (circ_busy),
    .cos_o   (circ_cos),
    .sin_o   (circ_sin)
  );

  csw_cordic u_cordic_sway (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .turn_i  (sway_phase_q),
    .busy_o  (sway_busy),
    .cos_o   (sway_cos),
    .sin_o   (sway_sin)
  );

  // The radius is capped at the reach limit.
  assign radius_eff = (radius_q > reach_q) ? reach_q : radius_q;
  assign radius_op  = {1'b0, radius_eff};

  // Three bit-serial multipliers scale the unit vectors.
  csw_sermul u_mul_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .frac_i  (circ_cos),
    .scale_i (radius_op),
    .busy_o  (mx_busy),
    .prod_o  (prod_x)
  );

  csw_sermul u_mul_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .frac_i  (sway_sin),
    .scale_i (sway_amp_q),
    .busy_o  (my_busy),
    .prod_o  (prod_y)
  );

  csw_sermul u_mul_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .frac_i  (circ_sin),
    .scale_i (radius_op),
    .busy_o  (mz_busy),
    .prod_o  (prod_z)
  );

  // Add the centers in a widened format before saturation.
  assign sum_x = csw_pkg::SUM_BITS'(center_x_q) + csw_pkg::SUM_BITS'(prod_x);
  assign sum_y = csw_pkg::SUM_BITS'(center_y_q) + csw_pkg::SUM_BITS'(prod_y);
  assign sum_z = csw_pkg::SUM_BITS'(center_z_q) + csw_pkg::SUM_BITS'(prod_z);

  // Output register: loaded when the point is done and the slot is free.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_FIN && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      tx_q <= csw_pkg::sat_pos(sum_x);
      ty_q <= csw_pkg::sat_pos(sum_y);
      tz_q <= csw_pkg::sat_pos(sum_z);
    end
  end

  assign out_ch.valid    = out_valid_q;
  assign out_ch.target_x = tx_q;
  assign out_ch.target_y = ty_q;
  assign out_ch.target_z = tz_q;

  // The cosine of the sway phase is not needed.
  logic unused_sway_cos;
  assign unused_sway_cos = ^sway_cos;

endmodule

// ----- hdl/csw_checker.sv -----
// ----------------------------------------------------------------------------
// Circular sway trajectory generator - port checker
// Concurrent checks on the channel ports, attached to the top level by bind.
// ----------------------------------------------------------------------------
module csw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  // A pending point is held until the receiver takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // Only one tick is in work: no new tick right after one is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("tick accepted while another is in work");

  // A point never appears in the cycle after a tick is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("output beat appeared too early after a tick");

  // While the sequencer works on a tick, the output can only rise when the
  // ready line was low in the previous cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("output beat without a tick in work");

endmodule

bind circular_sway_trajectory_generator csw_checker u_csw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready)
);
